// ===== rtl/tree_accumulate_core_assert.svh =====
// assertion helpers shared by the tree accumulate block
`ifndef TREE_ACCUMULATE_CORE_ASSERT_SVH
`define TREE_ACCUMULATE_CORE_ASSERT_SVH

// same-cycle implication, off while reset is low
`define TAC_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tree accumulate assertion failed");

// next-cycle implication, off while reset is low
`define TAC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tree accumulate assertion failed");

`endif

// ===== rtl/tac_pkg.sv =====
package tac_pkg;

  localparam int unsigned ID_W    = 12;
  localparam int unsigned ID_SPAN = 4096;
  localparam int unsigned VAL_W   = 64;

  // operation codes of an input word
  localparam logic OP_ROW    = 1'b0;
  localparam logic OP_REWIND = 1'b1;

  // direction register codes
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef struct packed {
    logic                    operation;
    logic [ID_W-1:0]         node_id;
    logic                    has_parent;
    logic [ID_W-1:0]         parent_id;
    logic signed [VAL_W-1:0] value;
    logic                    value_present;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] total;
    logic                    overflow_error;
  } out_word_t;

  // classified row as handed from front to back
  typedef struct packed {
    logic                    op;
    logic [ID_W-1:0]         node_id;
    logic                    node_ok;
    logic                    has_parent;
    logic [ID_W-1:0]         parent_id;
    logic                    parent_ok;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic clearing;
    logic error_latched;
  } tac_status_t;

endpackage

// ===== rtl/tac_front.sv =====
module tac_front #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tac_pkg::in_word_t in_data_i,
  input  logic              q_ready_i,
  output logic              q_push_o,
  output tac_pkg::item_t    q_item_o
);
  import tac_pkg::*;

  assign in_stall_o = !q_ready_i;
  assign q_push_o   = in_valid_i && q_ready_i;

  always_comb begin
    q_item_o.op         = in_data_i.operation;
    q_item_o.node_id    = in_data_i.node_id;
    q_item_o.has_parent = in_data_i.has_parent;
    q_item_o.parent_id  = in_data_i.parent_id;
    // ids outside the table read as zero and drop their writes
    q_item_o.node_ok    = (32'(in_data_i.node_id) < 32'(NODE_COUNT));
    q_item_o.parent_ok  = (32'(in_data_i.parent_id) < 32'(NODE_COUNT));
    // a null value counts as zero
    q_item_o.value      = in_data_i.value_present ? in_data_i.value : '0;
  end

endmodule

// ===== rtl/tac_queue.sv =====
module tac_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tac_pkg::item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  output tac_pkg::item_t item_o,
  input  logic           pop_i
);
  import tac_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/tac_back.sv =====
module tac_back #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 dir_i,
  input  logic                 q_valid_i,
  input  tac_pkg::item_t       q_item_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tac_pkg::out_word_t   out_data_o,
  output tac_pkg::tac_status_t status_o
);
  import tac_pkg::*;

  localparam int unsigned Depth = (NODE_COUNT < ID_SPAN) ? NODE_COUNT : ID_SPAN;
  localparam int unsigned AW    = $clog2(Depth);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_FIRST  = 4'b0100,
    S_SECOND = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic err_q, err_d;
  logic out_valid_q, out_valid_d;
  out_word_t out_data_q, out_data_d;
  item_t cur_q, cur_d;
  logic signed [VAL_W-1:0] total_q, total_d;

  logic [VAL_W-1:0] mem [Depth];
  logic [VAL_W-1:0] rdata_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic             slot_free;
  logic [VAL_W-1:0] opnd1, opnd2;
  logic [VAL_W:0]   add1, add2;

  // two's complement add with signed overflow flag in the top bit
  function automatic logic [VAL_W:0] add_ovf(input logic [VAL_W-1:0] a,
                                             input logic [VAL_W-1:0] b);
    logic [VAL_W-1:0] s;
    s = a + b;
    return {((a[VAL_W-1] ^ s[VAL_W-1]) & (b[VAL_W-1] ^ s[VAL_W-1])), s};
  endfunction

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    if (state_q == S_IDLE) begin
      mem_raddr = ((dir_i == DIR_DOWN) && q_item_i.has_parent) ?
                  q_item_i.parent_id[AW-1:0] : q_item_i.node_id[AW-1:0];
    end else begin
      mem_raddr = cur_q.parent_id[AW-1:0];
    end
  end

  always_comb begin
    if (dir_i == DIR_UP) begin
      opnd1 = cur_q.node_ok ? rdata_q : '0;
    end else begin
      opnd1 = (cur_q.has_parent && cur_q.parent_ok) ? rdata_q : '0;
    end
    opnd2 = cur_q.parent_ok ? rdata_q : '0;
    add1  = add_ovf(cur_q.value, opnd1);
    add2  = add_ovf(opnd2, total_q);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    err_d       = err_q;
    cur_d       = cur_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = clr_q;
    mem_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == AW'(Depth - 1)) begin
          clr_d   = '0;
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (q_valid_i && slot_free) begin
          q_pop_o = 1'b1;
          cur_d   = q_item_i;
          if (q_item_i.op == OP_REWIND) begin
            err_d       = 1'b0;
            out_valid_d = 1'b1;
            out_data_d  = '{total: '0, overflow_error: 1'b0};
            state_d     = S_CLEAR;
          end else if (err_q) begin
            out_valid_d = 1'b1;
            out_data_d  = '{total: '0, overflow_error: 1'b1};
          end else begin
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (add1[VAL_W]) begin
          err_d       = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = '{total: '0, overflow_error: 1'b1};
          state_d     = S_IDLE;
        end else if (dir_i == DIR_DOWN) begin
          mem_we      = cur_q.node_ok;
          mem_waddr   = cur_q.node_id[AW-1:0];
          mem_wdata   = add1[VAL_W-1:0];
          out_valid_d = 1'b1;
          out_data_d  = '{total: add1[VAL_W-1:0], overflow_error: 1'b0};
          state_d     = S_IDLE;
        end else if (!cur_q.has_parent) begin
          out_valid_d = 1'b1;
          out_data_d  = '{total: add1[VAL_W-1:0], overflow_error: 1'b0};
          state_d     = S_IDLE;
        end else begin
          total_d = add1[VAL_W-1:0];
          state_d = S_SECOND;
        end
      end
      S_SECOND: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (add2[VAL_W]) begin
          err_d      = 1'b1;
          out_data_d = '{total: '0, overflow_error: 1'b1};
        end else begin
          mem_we     = cur_q.parent_ok;
          mem_waddr  = cur_q.parent_id[AW-1:0];
          mem_wdata  = add2[VAL_W-1:0];
          out_data_d = '{total: total_q, overflow_error: 1'b0};
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    cur_q      <= cur_d;
    total_q    <= total_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign status_o    = '{clearing: (state_q == S_CLEAR), error_latched: err_q};

endmodule

// ===== rtl/tree_accumulate_core.sv =====
// Tree accumulator: takes tree rows (node id, optional parent id, signed 64-bit value,
// null values count as zero) and returns one word per row. With the direction register
// at 0 (up) rows must arrive children first; each row's total is its value plus the
// node's accumulated sum, and that total is added into the parent's entry (subtree
// sums). With direction 1 (down) rows arrive parents first; the total is the value
// plus the parent's entry and is stored at the node (root-path sums). A signed 64-bit
// overflow latches a sticky error: the word then carries total 0 and the error flag,
// and later rows are ignored until a rewind word, which clears the table and the error
// and returns total 0. Ids at or above NODE_COUNT read as zero and never get written.
// Timing: the sum table has one registered read port and one write port, so a row
// passes through the back end as a read, then an add and write, and in up mode with
// a parent as a node read, a parent read, then the add and write. After reset and
// after every rewind the table's min(NODE_COUNT, 4096) entries are zeroed one entry
// per cycle; meanwhile no row is taken from the queue, and the input side keeps
// accepting until the two-word queue fills. The direction register is written only
// while the block is idle; the user must keep to this, the block does not enforce it.
`include "tree_accumulate_core_assert.svh"

module tree_accumulate_core #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // row input
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tac_pkg::in_word_t  in_data_i,
  // result output
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tac_pkg::out_word_t out_data_o,
  // direction register write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);
  import tac_pkg::*;

  // direction register, always writable
  logic dir_q;

  // front to queue
  logic  f_push;
  item_t f_item;
  logic  q_ready;

  // queue to back
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  tac_status_t back_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_UP;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dir_q <= cfg_data_i;
    end
  end

  // front end: takes the word, masks null values, flags ids outside the table
  tac_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_ready_i  (q_ready),
    .q_push_o   (f_push),
    .q_item_o   (f_item)
  );

  // two-entry queue lets the input side keep taking words while the back end works
  tac_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  // back end: sum table, read-add-write sequencer, error latch, output register
  tac_back #(
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_i       (dir_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .status_o    (back_st)
  );

  // nothing leaves the queue while the table is being zeroed
  `TAC_ASSERT_IMPLY(a_no_pop_clear, clk_i, rst_ni, back_st.clearing, !q_pop)
  // a fresh overflow shows up as an error word in the same cycle
  `TAC_ASSERT_IMPLY(a_err_word, clk_i, rst_ni, $rose(back_st.error_latched), out_valid_o && out_data_o.overflow_error)
  // a rewind starts the clearing pass and drops the error
  `TAC_ASSERT_NEXT(a_rewind_clear, clk_i, rst_ni, q_pop && (q_item.op == OP_REWIND), back_st.clearing && !back_st.error_latched)

endmodule
